FILE: rtl/dirl_pkg.sv
// Shared types and constants for the DSP boot image record loader.
`default_nettype none

package dirl_pkg;

	localparam int WORD_W = 16;
	localparam int REM_W = 17;
	localparam int BYTE_W = 8;
	localparam int DM_SEL_BIT = 14;

	localparam logic [WORD_W-1:0] END_MARK = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_COUNT   = 3'd0,
		PH_ADDRESS = 3'd1,
		PH_ENTRY   = 3'd2,
		PH_PM_LOW  = 3'd3,
		PH_DONE    = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_PROG = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [WORD_W-1:0] addr;
		logic [WORD_W-1:0] word;
		logic [BYTE_W-1:0] low;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/dirl_seq.sv
// Record parser: phase, count, address and held word, with the result of each word.
`default_nettype none

module dirl_seq (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic [dirl_pkg::WORD_W-1:0]  word,
	output dirl_pkg::result_t                 result
);

	dirl_pkg::phase_t                   phase_q, phase_d;
	logic signed [dirl_pkg::REM_W-1:0]  remaining_q, remaining_d;
	logic [dirl_pkg::WORD_W-1:0]        addr_q, addr_d;
	logic [dirl_pkg::WORD_W-1:0]        held_q, held_d;
	logic signed [dirl_pkg::REM_W-1:0]  rem_less;
	logic                               is_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= dirl_pkg::PH_COUNT;
			remaining_q <= '0;
			addr_q      <= '0;
			held_q      <= '0;
		end else begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			addr_q      <= addr_d;
			held_q      <= held_d;
		end
	end

	assign is_data = addr_q[dirl_pkg::DM_SEL_BIT];
	// A data entry consumes one count, a program entry two.
	assign rem_less = is_data ? remaining_q - 17'sd1 : remaining_q - 17'sd2;

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		addr_d      = addr_q;
		held_d      = held_q;
		result      = '0;
		if (step) begin
			unique case (phase_q)
				dirl_pkg::PH_COUNT: begin
					if (word == dirl_pkg::END_MARK) begin
						phase_d      = dirl_pkg::PH_DONE;
						result.valid = 1'b1;
						result.kind  = dirl_pkg::KIND_END;
					end else begin
						remaining_d = {1'b0, word};
						phase_d     = dirl_pkg::PH_ADDRESS;
					end
				end
				dirl_pkg::PH_ADDRESS: begin
					addr_d  = word;
					phase_d = (remaining_q > 0) ? dirl_pkg::PH_ENTRY : dirl_pkg::PH_COUNT;
				end
				dirl_pkg::PH_ENTRY: begin
					if (is_data) begin
						result.valid = 1'b1;
						result.kind  = dirl_pkg::KIND_DATA;
						result.addr  = addr_q;
						result.word  = word;
						remaining_d  = rem_less;
						addr_d       = addr_q + 16'd1;
						phase_d      = (rem_less > 0) ? dirl_pkg::PH_ENTRY
						                              : dirl_pkg::PH_COUNT;
					end else begin
						held_d  = word;
						phase_d = dirl_pkg::PH_PM_LOW;
					end
				end
				dirl_pkg::PH_PM_LOW: begin
					result.valid = 1'b1;
					result.kind  = dirl_pkg::KIND_PROG;
					result.addr  = addr_q;
					result.word  = held_q;
					result.low   = word[dirl_pkg::BYTE_W-1:0];
					remaining_d  = rem_less;
					addr_d       = addr_q + 16'd1;
					phase_d      = (rem_less > 0) ? dirl_pkg::PH_ENTRY : dirl_pkg::PH_COUNT;
				end
				default: begin
				end
			endcase
		end
	end

	a_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == dirl_pkg::PH_DONE |=> phase_q == dirl_pkg::PH_DONE)
		else $error("finished phase was left");

	a_entry_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == dirl_pkg::PH_ENTRY |-> remaining_q > 0)
		else $error("entry phase with no count left");

	a_pm_low_prog_addr: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == dirl_pkg::PH_PM_LOW |-> !addr_q[dirl_pkg::DM_SEL_BIT])
		else $error("program low word at a data address");

	a_end_from_marker: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind == dirl_pkg::KIND_END |->
		word == dirl_pkg::END_MARK && phase_q == dirl_pkg::PH_COUNT)
		else $error("end result without end marker");

endmodule

`default_nettype wire

FILE: rtl/dsp_image_record_loader.sv
// Top level of the DSP boot image record loader.
// Takes one 16-bit image word per beat and returns at most one write (data, program or
// end of image) for it. A word is registered at the input, parsed from that register by
// the record state machine, and the result lands in an output register, so one word is
// taken every cycle while the result side keeps up. The output register alone sets
// back-pressure: when it holds an untaken result, parsing pauses and the input register
// fills before the input stalls.
`default_nettype none

module dsp_image_record_loader (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] image_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [15:0]      target_address,
	output logic [15:0]      write_word,
	output logic [7:0]       program_low_byte
);

	logic                            valid_s1;
	logic [dirl_pkg::WORD_W-1:0]     word_s1;
	logic                            valid_s2;
	dirl_pkg::result_t               res_s2;
	dirl_pkg::result_t               res_comb;
	logic                            advance;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= image_word;
		end
	end

	dirl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.word   (word_s1),
		.result (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && res_comb.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid        = valid_s2;
	assign kind             = res_s2.kind;
	assign target_address   = res_s2.addr;
	assign write_word       = res_s2.word;
	assign program_low_byte = res_s2.low;

endmodule

`default_nettype wire

FILE: test/dirl_write_checker.sv
`timescale 1ns / 100ps
// Beat monitor for the boot image loader: predicts each write and compares it with the output.
module dirl_write_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [dirl_pkg::WORD_W-1:0] image_word,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [1:0]                  kind,
	input  logic [dirl_pkg::WORD_W-1:0] target_address,
	input  logic [dirl_pkg::WORD_W-1:0] write_word,
	input  logic [dirl_pkg::BYTE_W-1:0] program_low_byte,
	output int                          fail_count,
	output int                          pending_writes,
	output int                          checked_writes
);

	typedef struct packed {
		dirl_pkg::kind_t             kind;
		logic [dirl_pkg::WORD_W-1:0] addr;
		logic [dirl_pkg::WORD_W-1:0] word;
		logic [dirl_pkg::BYTE_W-1:0] low;
	} image_write_t;

	image_write_t expected_writes[$];
	image_write_t oldest;

	dirl_pkg::phase_t                   parse_phase;
	logic signed [dirl_pkg::REM_W-1:0]  words_left;
	logic [dirl_pkg::WORD_W-1:0]        entry_addr;
	logic [dirl_pkg::WORD_W-1:0]        held_word;
	int                                 errors;
	int                                 checked;

	task automatic queue_write(input dirl_pkg::kind_t k,
			input logic [dirl_pkg::WORD_W-1:0] addr,
			input logic [dirl_pkg::WORD_W-1:0] word,
			input logic [dirl_pkg::BYTE_W-1:0] low);
		image_write_t wr;
		wr.kind = k;
		wr.addr = addr;
		wr.word = word;
		wr.low = low;
		expected_writes.push_back(wr);
	endtask

	task automatic retire_entry(input int used);
		words_left = words_left - dirl_pkg::REM_W'(used);
		entry_addr = entry_addr + 1'b1;
		parse_phase = (words_left > 0) ? dirl_pkg::PH_ENTRY : dirl_pkg::PH_COUNT;
	endtask

	task automatic parse_image_word(input logic [dirl_pkg::WORD_W-1:0] w);
		case (parse_phase)
			dirl_pkg::PH_COUNT: begin
				if (w == dirl_pkg::END_MARK) begin
					parse_phase = dirl_pkg::PH_DONE;
					queue_write(dirl_pkg::KIND_END, '0, '0, '0);
				end else begin
					words_left = $signed({1'b0, w});
					parse_phase = dirl_pkg::PH_ADDRESS;
				end
			end
			dirl_pkg::PH_ADDRESS: begin
				entry_addr = w;
				parse_phase = (words_left > 0) ? dirl_pkg::PH_ENTRY : dirl_pkg::PH_COUNT;
			end
			dirl_pkg::PH_ENTRY: begin
				if (entry_addr[dirl_pkg::DM_SEL_BIT]) begin
					queue_write(dirl_pkg::KIND_DATA, entry_addr, w, '0);
					retire_entry(1);
				end else begin
					held_word = w;
					parse_phase = dirl_pkg::PH_PM_LOW;
				end
			end
			dirl_pkg::PH_PM_LOW: begin
				queue_write(dirl_pkg::KIND_PROG, entry_addr, held_word,
					w[dirl_pkg::BYTE_W-1:0]);
				retire_entry(2);
			end
			// Once the end marker is seen, every later word is dropped.
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_phase = dirl_pkg::PH_COUNT;
			words_left = '0;
			entry_addr = '0;
			held_word = '0;
			expected_writes.delete();
			errors = 0;
			checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_writes.size() == 0) begin
					$error("write with nothing expected: kind %0d, address %h, word %h",
						kind, target_address, write_word);
					errors++;
				end else begin
					oldest = expected_writes.pop_front();
					if (kind !== oldest.kind) begin
						$error("kind: expected %0d, got %0d", oldest.kind, kind);
						errors++;
					end
					if (target_address !== oldest.addr) begin
						$error("target_address: expected %h, got %h", oldest.addr, target_address);
						errors++;
					end
					if (write_word !== oldest.word) begin
						$error("write_word: expected %h, got %h", oldest.word, write_word);
						errors++;
					end
					if (program_low_byte !== oldest.low) begin
						$error("program_low_byte: expected %h, got %h", oldest.low,
							program_low_byte);
						errors++;
					end
					checked++;
				end
			end
			if (in_valid && in_ready) begin
				parse_image_word(image_word);
			end
		end
		// Outputs change after the edge, so the top always samples a settled value.
		fail_count <= errors;
		pending_writes <= expected_writes.size();
		checked_writes <= checked;
	end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench top for the boot image loader: drives image records, paces both sides, gives the verdict.
module tb;

	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD = 150;
	localparam int PHASE_WORDS = 530;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic [dirl_pkg::WORD_W-1:0] image_word;
	logic                        out_valid;
	logic                        out_ready;
	logic [1:0]                  kind;
	logic [dirl_pkg::WORD_W-1:0] target_address;
	logic [dirl_pkg::WORD_W-1:0] write_word;
	logic [dirl_pkg::BYTE_W-1:0] program_low_byte;

	int   fail_count;
	int   pending_writes;
	int   checked_writes;
	int   src_idle_pct;
	int   sink_idle_pct;
	int   words_sent;
	int   records_sent;
	logic hold_toggle;

	dsp_image_record_loader DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.image_word       (image_word),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kind             (kind),
		.target_address   (target_address),
		.write_word       (write_word),
		.program_low_byte (program_low_byte)
	);

	dirl_write_checker write_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.image_word       (image_word),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kind             (kind),
		.target_address   (target_address),
		.write_word       (write_word),
		.program_low_byte (program_low_byte),
		.fail_count       (fail_count),
		.pending_writes   (pending_writes),
		.checked_writes   (checked_writes)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result side: random stalls, plus a long hold-off each time hold_toggle flips.
	initial begin : result_sink
		int   hold_left;
		logic seen_toggle;
		hold_left = 0;
		seen_toggle = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_toggle != seen_toggle) begin
				seen_toggle = hold_toggle;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("Timeout: no beat for %0d cycles", STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [dirl_pkg::WORD_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return dirl_pkg::END_MARK;
			1: return '0;
			default: return dirl_pkg::WORD_W'($urandom());
		endcase
	endfunction

	task automatic send_word(input logic [dirl_pkg::WORD_W-1:0] w);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		image_word <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
	endtask

	// Walks the entries of a record to know how many payload words it takes.
	task automatic send_record(input logic [dirl_pkg::WORD_W-1:0] count,
			input logic [dirl_pkg::WORD_W-1:0] addr);
		int                          left;
		int                          payload;
		logic [dirl_pkg::WORD_W-1:0] a;
		left = count;
		a = addr;
		payload = 0;
		while (left > 0) begin
			payload += a[dirl_pkg::DM_SEL_BIT] ? 1 : 2;
			left -= a[dirl_pkg::DM_SEL_BIT] ? 1 : 2;
			a++;
		end
		send_word(count);
		send_word(addr);
		repeat (payload) send_word(rand_word());
		records_sent++;
	endtask

	task automatic send_random_records(input int n_words);
		int                          stop_at;
		int                          pick;
		logic [dirl_pkg::WORD_W-1:0] count;
		logic [dirl_pkg::WORD_W-1:0] addr;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) count = '0;
			else if (pick < 75) count = dirl_pkg::WORD_W'($urandom_range(1, 8));
			else if (pick < 95) count = dirl_pkg::WORD_W'($urandom_range(9, 40));
			else count = dirl_pkg::WORD_W'($urandom_range(41, 200));
			// Half the records start near a memory select or wrap boundary.
			if ($urandom_range(0, 1)) begin
				addr = dirl_pkg::WORD_W'($urandom());
			end else begin
				addr = dirl_pkg::WORD_W'((($urandom_range(0, 3) + 1) << 14) - 8
					+ $urandom_range(0, 15));
			end
			send_record(count, addr);
		end
	endtask

	task automatic drain_writes();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_writes != 0) @(posedge clk);
	endtask

	initial begin
		in_valid = 1'b0;
		image_word = '0;
		hold_toggle = 1'b0;
		src_idle_pct = 12;
		sink_idle_pct = 85;
		words_sent = 0;
		records_sent = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Zero count: the address word is followed directly by the next count.
		send_word(16'h0000);
		send_word(16'hFFFF);
		// Odd count that ends on a program entry.
		send_word(16'h0001);
		send_word(16'h3FFF);
		send_word(16'hFFFF);
		send_word(16'h00FF);
		// Data entry at 0x7FFF, then a program entry once bit 14 clears.
		send_word(16'h0003);
		send_word(16'h7FFF);
		send_word(16'h0000);
		send_word(16'h1234);
		send_word(16'hFF00);
		// Address wraps from 0xFFFF to zero in the middle of a record.
		send_word(16'h0002);
		send_word(16'hFFFF);
		send_word(16'hFFFF);
		send_word(16'hA5A5);
		send_word(16'h5A5A);
		send_word(16'h0004);
		send_word(16'h4000);
		send_word(16'h0000);
		send_word(16'hFFFF);
		send_word(16'hAAAA);
		send_word(16'h5555);
		records_sent += 5;
		drain_writes();

		send_random_records(PHASE_WORDS / 2);
		hold_toggle <= ~hold_toggle;
		send_random_records(PHASE_WORDS / 2);
		drain_writes();

		src_idle_pct = 85;
		sink_idle_pct = 12;
		send_random_records(PHASE_WORDS);
		drain_writes();

		src_idle_pct = 0;
		sink_idle_pct = 0;
		hold_toggle <= ~hold_toggle;
		send_random_records(PHASE_WORDS);
		// A longer record that runs from program memory into data memory.
		send_record(16'h0040, 16'h3FF8);
		send_word(dirl_pkg::END_MARK);
		// Anything after the end marker must be dropped.
		repeat (8) send_word(rand_word());
		drain_writes();
		repeat (8) @(posedge clk);

		if (pending_writes != 0) begin
			$error("%0d expected writes never arrived", pending_writes);
		end
		$display("Sent %0d image words in %0d records and checked %0d writes.",
			words_sent, records_sent, checked_writes);
		$display("Covered zero, odd and long counts, boundary addresses, the end and after it.");
		if (fail_count == 0 && pending_writes == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
